// ----- rtl/sm4_block_encrypt_macros.svh -----
// ----------------------------------------------------------------------------
// sm4_block_encrypt_macros.svh
// Assertion macros for the SM4 block encrypt engine; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef SM4_BLOCK_ENCRYPT_MACROS_SVH
`define SM4_BLOCK_ENCRYPT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define SM4_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define SM4_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SM4_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define SM4_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

// ----- rtl/sm4_pkg.sv -----
// ----------------------------------------------------------------------------
// sm4_pkg
// Shared widths, types, codes and the SM4 S-box.
// ----------------------------------------------------------------------------
package sm4_pkg;

   localparam int WORD_W     = 32;
   localparam int NUM_ROUNDS = 32;
   localparam int SLOT_W     = $clog2(NUM_ROUNDS);

   typedef logic [WORD_W-1:0]           sm4_word_type;
   typedef logic [SLOT_W-1:0]           sm4_slot_type;
   typedef logic [3:0][WORD_W-1:0]      sm4_block_type;   // [0] is the first word

   localparam sm4_slot_type LAST_ROUND = SLOT_W'(NUM_ROUNDS - 1);

   // request function codes
   localparam logic FUNC_LOAD_KEY = 1'b0;
   localparam logic FUNC_ENCRYPT  = 1'b1;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } sm4_state_type;

   localparam logic [7:0] SBOX [256] = '{
      8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
      8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
      8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
      8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
      8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
      8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
      8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
      8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
      8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
      8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
      8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
      8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
      8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
      8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
      8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
      8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
   };

endpackage

// ----- rtl/sm4_req_if.sv -----
// ----------------------------------------------------------------------------
// sm4_req_if
// Request channel: key load or block encrypt beats.
// ----------------------------------------------------------------------------
interface sm4_req_if
   import sm4_pkg::*;
();
   logic         valid;
   logic         ready;
   logic         func;
   sm4_slot_type key_slot;
   sm4_word_type key_word;
   sm4_word_type plain_word0;
   sm4_word_type plain_word1;
   sm4_word_type plain_word2;
   sm4_word_type plain_word3;

   modport source (
      output valid, func, key_slot, key_word,
             plain_word0, plain_word1, plain_word2, plain_word3,
      input  ready
   );

   modport sink (
      input  valid, func, key_slot, key_word,
             plain_word0, plain_word1, plain_word2, plain_word3,
      output ready
   );
endinterface

// ----- rtl/sm4_rsp_if.sv -----
// ----------------------------------------------------------------------------
// sm4_rsp_if
// Response channel: one ciphertext block per beat.
// ----------------------------------------------------------------------------
interface sm4_rsp_if
   import sm4_pkg::*;
();
   logic         valid;
   logic         ready;
   sm4_word_type cipher_word0;
   sm4_word_type cipher_word1;
   sm4_word_type cipher_word2;
   sm4_word_type cipher_word3;

   modport source (
      output valid, cipher_word0, cipher_word1, cipher_word2, cipher_word3,
      input  ready
   );

   modport sink (
      input  valid, cipher_word0, cipher_word1, cipher_word2, cipher_word3,
      output ready
   );
endinterface

// ----- rtl/sm4_round.sv -----
// ----------------------------------------------------------------------------
// sm4_round
// One SM4 round: key mix, byte substitution, linear diffusion.
// ----------------------------------------------------------------------------
module sm4_round
   import sm4_pkg::*;
(
   input  sm4_block_type words,
   input  sm4_word_type  round_key,
   output sm4_word_type  next_word
);

   function automatic sm4_word_type rotl(input sm4_word_type v, input int unsigned n);
      rotl = (v << n) | (v >> (WORD_W - n));
   endfunction

   sm4_word_type mix_in;
   sm4_word_type sub_out;
   sm4_word_type diff_out;

   always_comb begin
      mix_in = words[1] ^ words[2] ^ words[3] ^ round_key;
      for (int i = 0; i < 4; i++) begin
         sub_out[8*i +: 8] = SBOX[mix_in[8*i +: 8]];
      end
      diff_out = sub_out ^ rotl(sub_out, 2) ^ rotl(sub_out, 10)
               ^ rotl(sub_out, 18) ^ rotl(sub_out, 24);
      next_word = words[0] ^ diff_out;
   end

endmodule

// ----- rtl/sm4_block_encrypt.sv -----
// ----------------------------------------------------------------------------
// sm4_block_encrypt
// SM4 block encryption engine with an internal 32-entry round key memory.
// ----------------------------------------------------------------------------
// Usage:
//  - req_bus carries two kinds of beat, chosen by func. A key-load beat writes
//    key_word into round key slot key_slot and gives no response. An encrypt
//    beat carries the four plaintext words and gives one response beat on
//    rsp_bus with the four ciphertext words.
//  - All 32 round keys must be loaded before the first encrypt beat.
//  - One round runs per cycle, except that the last round holds while the
//    output register is full, through a single round unit fed by the key
//    memory, whose registered read is issued in the cycle before its round.
//  - Throughput: a new block is taken only once the last one has run its
//    32 rounds and returned to idle; one key load per cycle while idle.
//  - The request side takes a new beat while a finished block still waits on
//    rsp_bus. If the receiver stalls long enough that a second block reaches
//    its last round with the output register full, that round holds until
//    the output register is free.
//  - Reset (synchronous) clears the control state and drops rsp valid; the
//    key memory keeps no defined contents and must be reloaded.
// ----------------------------------------------------------------------------
`include "sm4_block_encrypt_macros.svh"

module sm4_block_encrypt
   import sm4_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   sm4_req_if.sink    req_bus,
   sm4_rsp_if.source  rsp_bus
);

   // key memory, one entry per round
   sm4_word_type  key_mem [NUM_ROUNDS];
   sm4_word_type  rd_key_ff;
   sm4_slot_type  rd_addr;
   logic          key_we;

   // control
   sm4_state_type state_ff, state_in;
   sm4_slot_type  rnd_ff, rnd_in;

   // block datapath: sliding window of four round words
   sm4_block_type w_ff, w_in;
   sm4_word_type  next_word;

   // output register
   logic          rsp_valid_ff, rsp_valid_in;
   sm4_block_type out_ff, out_in;

   logic          req_ready;
   logic          req_fire;
   logic          out_free;
   logic          last_round;

   // requests are taken only between blocks
   assign req_ready  = (state_ff == ST_IDLE);
   assign req_fire   = req_bus.valid && req_ready;
   assign out_free   = !rsp_valid_ff || rsp_bus.ready;
   assign last_round = (rnd_ff == LAST_ROUND);

   sm4_round u_round (
      .words     (w_ff),
      .round_key (rd_key_ff),
      .next_word (next_word)
   );

   // key memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[req_bus.key_slot] <= req_bus.key_word;
      end
      rd_key_ff <= key_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rnd_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rnd_ff       <= rnd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      w_ff   <= w_in;
      out_ff <= out_in;
   end

   always_comb begin
      state_in     = state_ff;
      rnd_in       = rnd_ff;
      w_in         = w_ff;
      out_in       = out_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rd_addr      = rnd_ff;
      key_we       = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            // prefetch the first round key for an incoming block
            rd_addr   = '0;
            if (req_fire) begin
               if (req_bus.func == FUNC_ENCRYPT) begin
                  w_in[0]  = req_bus.plain_word0;
                  w_in[1]  = req_bus.plain_word1;
                  w_in[2]  = req_bus.plain_word2;
                  w_in[3]  = req_bus.plain_word3;
                  rnd_in   = '0;
                  state_in = ST_RUN;
               end else begin
                  key_we = 1'b1;
               end
            end
         end
         ST_RUN: begin
            // last round waits for a free output register; keep its key
            if (!(last_round && !out_free)) begin
               w_in    = {next_word, w_ff[3], w_ff[2], w_ff[1]};
               rnd_in  = SLOT_W'(rnd_ff + 1'b1);
               rd_addr = SLOT_W'(rnd_ff + 1'b1);
               if (last_round) begin
                  // ciphertext is X35, X34, X33, X32
                  out_in[0]    = next_word;
                  out_in[1]    = w_ff[3];
                  out_in[2]    = w_ff[2];
                  out_in[3]    = w_ff[1];
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end
            end
         end
      endcase
   end

   assign req_bus.ready        = req_ready;
   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.cipher_word0 = out_ff[0];
   assign rsp_bus.cipher_word1 = out_ff[1];
   assign rsp_bus.cipher_word2 = out_ff[2];
   assign rsp_bus.cipher_word3 = out_ff[3];

   // an accepted encrypt beat starts at round zero
   `SM4_ASSERT_NXT(a_start_round0, clock, reset,
      req_fire && (req_bus.func == FUNC_ENCRYPT),
      (state_ff == ST_RUN) && (rnd_ff == '0),
      "encrypt beat did not start at round zero")
   // finishing the last round with a free slot raises a response
   `SM4_ASSERT_NXT(a_last_gives_rsp, clock, reset,
      (state_ff == ST_RUN) && last_round && out_free,
      rsp_valid_ff && (state_ff == ST_IDLE),
      "last round did not produce a response")
   // a blocked last round holds its position
   `SM4_ASSERT_NXT(a_last_holds, clock, reset,
      (state_ff == ST_RUN) && last_round && !out_free,
      (state_ff == ST_RUN) && (rnd_ff == LAST_ROUND),
      "blocked last round moved on")
   // a new response only comes out of the round loop
   `SM4_ASSERT_IMP(a_rsp_from_run, clock, reset,
      $rose(rsp_valid_ff),
      $past(state_ff) == ST_RUN,
      "response raised outside the round loop")

endmodule

// ----- bench/sm4_block_encrypt_test.sv -----
// ----------------------------------------------------------------------------
// sm4_block_encrypt_test
// Self-checking bench for the SM4 block encrypt engine. Round keys are loaded
// through the request channel, blocks are encrypted, and every ciphertext
// beat is compared word by word against a behavioral SM4 round model that
// tracks the key memory. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module sm4_block_encrypt_test
   import sm4_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned RANDOM_ITEMS = 950;
   localparam int unsigned IDLE_LIMIT   = 4000;  // cycles with no beat on either side
   localparam int unsigned SHOW_LIMIT   = 10;    // mismatches printed in full
   localparam int unsigned TAIL_CYCLES  = 40;    // quiet time after the last result

   // one request beat as the bench sees it
   typedef struct packed {
      logic         func;
      sm4_slot_type slot;
      sm4_word_type key;
      sm4_word_type p0;
      sm4_word_type p1;
      sm4_word_type p2;
      sm4_word_type p3;
   } sm4_beat_type;

   // Directed beats, run after every slot has been loaded with zero.
   // Ignored fields carry a mix of zero and non-zero values so that leakage shows up.
   localparam sm4_beat_type DIRECTED_BEATS [14] = '{
      // all-zero keys, extreme blocks
      '{FUNC_ENCRYPT,  5'd0,  32'h0000_0000,
        32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000},
      '{FUNC_ENCRYPT,  5'd31, 32'hffff_ffff,
        32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff},
      '{FUNC_ENCRYPT,  5'd7,  32'hdead_beef,
        32'h0123_4567, 32'h89ab_cdef, 32'hfedc_ba98, 32'h7654_3210},
      // first and last slot to all ones; plaintext fields must be ignored
      '{FUNC_LOAD_KEY, 5'd0,  32'hffff_ffff,
        32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff},
      '{FUNC_LOAD_KEY, 5'd31, 32'hffff_ffff,
        32'h0000_0000, 32'h1111_1111, 32'h2222_2222, 32'h3333_3333},
      '{FUNC_ENCRYPT,  5'd0,  32'h0000_0000,
        32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000},
      '{FUNC_ENCRYPT,  5'd0,  32'h0000_0000,
        32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff},
      // checkerboard keys in the middle rounds
      '{FUNC_LOAD_KEY, 5'd15, 32'haaaa_aaaa,
        32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa},
      '{FUNC_LOAD_KEY, 5'd16, 32'h5555_5555,
        32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555},
      '{FUNC_ENCRYPT,  5'd16, 32'hffff_0000,
        32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555},
      '{FUNC_ENCRYPT,  5'd1,  32'h0000_ffff,
        32'h8000_0000, 32'h0000_0001, 32'h8000_0001, 32'h7fff_fffe},
      // same slot written twice in a row: the second write wins
      '{FUNC_LOAD_KEY, 5'd0,  32'h0000_0000,
        32'hffff_ffff, 32'h0000_0000, 32'hffff_ffff, 32'h0000_0000},
      '{FUNC_LOAD_KEY, 5'd0,  32'h1234_5678,
        32'h0000_0000, 32'hffff_ffff, 32'h0000_0000, 32'hffff_ffff},
      '{FUNC_ENCRYPT,  5'd31, 32'hffff_ffff,
        32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   sm4_req_if req_if();
   sm4_rsp_if rsp_if();

   sm4_block_encrypt u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // bench copy of the key memory and the ciphertext still owed
   sm4_word_type  round_keys [NUM_ROUNDS];
   sm4_block_type pending_cipher [$];

   int unsigned fail_count  = 0;
   int unsigned n_loads     = 0;
   int unsigned n_blocks    = 0;
   int unsigned n_checked   = 0;
   int unsigned max_backlog = 0;
   int unsigned idle_cycles = 0;
   bit          req_up      = 1'b0;  // valid left high after the last accepted beat
   bit          no_gaps     = 1'b0;  // sender runs back to back while set

   function automatic sm4_word_type rotl(sm4_word_type v, int unsigned n);
      return (v << n) | (v >> (WORD_W - n));
   endfunction

   // 32 SM4 rounds over the current key memory; [0] of the result is X35
   function automatic sm4_block_type sm4_encrypt(sm4_beat_type b);
      sm4_word_type  x [4];
      sm4_word_type  t;
      sm4_word_type  s;
      sm4_word_type  nw;
      sm4_block_type c;
      int            r;
      int            i;
      x[0] = b.p0;
      x[1] = b.p1;
      x[2] = b.p2;
      x[3] = b.p3;
      for (r = 0; r < NUM_ROUNDS; r++) begin
         t = x[1] ^ x[2] ^ x[3] ^ round_keys[r];
         for (i = 0; i < 4; i++) s[8*i +: 8] = SBOX[t[8*i +: 8]];
         nw = x[0] ^ s ^ rotl(s, 2) ^ rotl(s, 10) ^ rotl(s, 18) ^ rotl(s, 24);
         x[0] = x[1];
         x[1] = x[2];
         x[2] = x[3];
         x[3] = nw;
      end
      c[0] = x[3];
      c[1] = x[2];
      c[2] = x[1];
      c[3] = x[0];
      return c;
   endfunction

   // mostly short gaps, now and then a long one
   function automatic int unsigned pick_gap(int unsigned longest);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, longest);
   endfunction

   // random word with the all-zero and all-one patterns weighted in
   function automatic sm4_word_type rand_word();
      case ($urandom_range(0, 15))
         0: begin
            return '0;
         end
         1: begin
            return '1;
         end
         default: begin
            return $urandom();
         end
      endcase
   endfunction

   task automatic note_failure(string msg);
      fail_count++;
      if (fail_count <= SHOW_LIMIT) $display("mismatch: %s", msg);
   endtask

   // ---------------------------------------------------------------------
   // Request driver. valid stays high across back-to-back beats, so each
   // time step carries a single assignment to it.
   // ---------------------------------------------------------------------
   task automatic drop_req_valid();
      if (req_up) begin
         req_if.valid <= 1'b0;
         req_up = 1'b0;
      end
   endtask

   task automatic send_beat(sm4_beat_type b);
      int unsigned gap;
      req_if.valid       <= 1'b1;
      req_if.func        <= b.func;
      req_if.key_slot    <= b.slot;
      req_if.key_word    <= b.key;
      req_if.plain_word0 <= b.p0;
      req_if.plain_word1 <= b.p1;
      req_if.plain_word2 <= b.p2;
      req_if.plain_word3 <= b.p3;
      req_up = 1'b1;
      do @(posedge clock); while (!req_if.ready);
      gap = no_gaps ? 0 : pick_gap(60);
      if (gap != 0) begin
         drop_req_valid();
         repeat (gap) @(posedge clock);
      end
   endtask

   // sender holds off until every ciphertext beat owed has come back
   task automatic wait_drained();
      drop_req_valid();
      do @(posedge clock); while (pending_cipher.size() != 0);
   endtask

   task automatic send_random(logic func, sm4_slot_type slot);
      sm4_beat_type b;
      b.func = func;
      b.slot = slot;
      b.key  = rand_word();
      b.p0   = rand_word();
      b.p1   = rand_word();
      b.p2   = rand_word();
      b.p3   = rand_word();
      send_beat(b);
   endtask

   // ---------------------------------------------------------------------
   // Response sink: ready high for a stretch, then a stall. Long stretches
   // give idle-free windows; long stalls back the engine up behind a full
   // output register.
   // ---------------------------------------------------------------------
   initial begin
      int unsigned hold;
      int unsigned stall;
      rsp_if.ready = 1'b0;
      @(posedge clock);
      forever begin
         hold = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 200) : $urandom_range(1, 8);
         rsp_if.ready <= 1'b1;
         repeat (hold) @(posedge clock);
         stall = pick_gap(80);
         if (stall != 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: predicts on every accepted request beat, checks every
   // accepted response beat, and runs the watchdog.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      sm4_beat_type  b;
      sm4_block_type got;
      sm4_block_type want;
      int            w;
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            b = '{req_if.func, req_if.key_slot, req_if.key_word,
                  req_if.plain_word0, req_if.plain_word1,
                  req_if.plain_word2, req_if.plain_word3};
            if (b.func == FUNC_LOAD_KEY) begin
               round_keys[b.slot] = b.key;
               n_loads++;
            end else begin
               pending_cipher.push_back(sm4_encrypt(b));
               n_blocks++;
               if (pending_cipher.size() > max_backlog) max_backlog = pending_cipher.size();
            end
         end

         if (rsp_if.valid && rsp_if.ready) begin
            got[0] = rsp_if.cipher_word0;
            got[1] = rsp_if.cipher_word1;
            got[2] = rsp_if.cipher_word2;
            got[3] = rsp_if.cipher_word3;
            if (pending_cipher.size() == 0) begin
               note_failure($sformatf("ciphertext beat with none owed: %h %h %h %h",
                                      got[0], got[1], got[2], got[3]));
            end else begin
               want = pending_cipher.pop_front();
               for (w = 0; w < 4; w++) begin
                  if (got[w] !== want[w])
                     note_failure($sformatf("block %0d cipher_word%0d: expected %h, got %h",
                                            n_checked, w, want[w], got[w]));
               end
               n_checked++;
            end
         end

         // watchdog: a run that stops moving is a failure
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
               $display("watchdog: %0d cycles without a beat, %0d blocks owed",
                        IDLE_LIMIT, pending_cipher.size());
               $display("FAIL");
               $finish;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   initial begin
      sm4_beat_type b;
      int unsigned  n;
      int unsigned  k;
      int unsigned  pick;
      int unsigned  start;
      bit           paused;
      req_if.valid       = 1'b0;
      req_if.func        = FUNC_LOAD_KEY;
      req_if.key_slot    = '0;
      req_if.key_word    = '0;
      req_if.plain_word0 = '0;
      req_if.plain_word1 = '0;
      req_if.plain_word2 = '0;
      req_if.plain_word3 = '0;
      paused = 1'b0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Every slot gets a defined key before the first encrypt beat; zero
      // keys double as the all-zero key extreme. Plaintext fields are noise.
      for (n = 0; n < NUM_ROUNDS; n++) begin
         b = '{FUNC_LOAD_KEY, sm4_slot_type'(n), 32'h0, rand_word(), rand_word(),
               rand_word(), rand_word()};
         send_beat(b);
      end

      foreach (DIRECTED_BEATS[i]) send_beat(DIRECTED_BEATS[i]);
      wait_drained();

      // Random part: mostly encrypt beats under the current key set, single
      // key rewrites, and now and then a full fresh key set in a burst.
      n = 0;
      while (n < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 4) begin
            start = $urandom_range(0, NUM_ROUNDS - 1);
            for (k = 0; k < NUM_ROUNDS; k++)
               send_random(FUNC_LOAD_KEY, sm4_slot_type'((start + k) % NUM_ROUNDS));
            n += NUM_ROUNDS;
         end else if (pick < 30) begin
            send_random(FUNC_LOAD_KEY, sm4_slot_type'($urandom_range(0, NUM_ROUNDS - 1)));
            n++;
         end else begin
            send_random(FUNC_ENCRYPT, sm4_slot_type'($urandom_range(0, NUM_ROUNDS - 1)));
            n++;
         end

         if ($urandom_range(0, 63) == 0) no_gaps = !no_gaps;

         // full drain at midpoint unless one already happened, and rarely at random
         if ((!paused && n >= RANDOM_ITEMS / 2) || $urandom_range(0, 149) == 0) begin
            paused = 1'b1;
            wait_drained();
         end
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_cipher.size() != 0)
         note_failure($sformatf("%0d ciphertext beats never came", pending_cipher.size()));

      $display("run: %0d key loads, %0d encrypt beats, %0d ciphertext beats checked",
               n_loads, n_blocks, n_checked);
      $display("run: deepest result backlog %0d, %0d failures", max_backlog, fail_count);
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/sm4_pkg.sv
rtl/sm4_req_if.sv
rtl/sm4_rsp_if.sv
rtl/sm4_round.sv
rtl/sm4_block_encrypt.sv
bench/sm4_block_encrypt_test.sv
